[rtl/core/rls_pkg.sv]
// ----------------------------------------------------------------------------
// rls_pkg
// Shared widths, codes and command types of the two-parameter RLS estimator.
// ----------------------------------------------------------------------------
package rls_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int LamWidth  = FracBits + 1;
   localparam int DelWidth  = DataWidth - 1;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int AddrWidth = 4;

   localparam logic [LamWidth-1:0] LamOne = LamWidth'(1) << FracBits;
   localparam logic signed [DataWidth-1:0] SMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] SMin = {1'b1, {(DataWidth-1){1'b0}}};

   typedef logic signed [DataWidth-1:0] word_type;

   typedef enum logic [1:0] {
      OP_UPDATE  = 2'd0,
      OP_RESTART = 2'd1,
      OP_LOAD    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [AddrWidth-1:0] REG_LAMBDA = 4'h0;
   localparam logic [AddrWidth-1:0] REG_DELTA  = 4'h4;
   localparam logic [AddrWidth-1:0] REG_THETA0 = 4'h8;
   localparam logic [AddrWidth-1:0] REG_THETA1 = 4'hc;

   // datapath register file index
   typedef enum logic [3:0] {
      R_P00, R_P01, R_P10, R_P11, R_TH0, R_TH1, R_PHI0, R_PHI1,
      R_Y, R_T0, R_T1, R_DEN, R_K0, R_K1, R_ERR, R_S0
   } reg_type;

   // one step of the datapath microprogram
   typedef enum logic [2:0] {
      DO_IDLE,     // nothing
      DO_MULACC,   // acc = sat(mulq(a,b) + mulq(c,d)), sat(c + mulq(a,b)) or sat(c - mulq(a,b))
      DO_DIV,      // quotient of a by den or lambda
      DO_ADDLAM,   // den = sat(lambda + den), zero forced to one
      DO_SUB       // dst = sat(rc - ra), plain register difference
   } dop_type;

   typedef struct packed {
      dop_type     dop;
      reg_type     ra;
      reg_type     rb;
      reg_type     rc;
      reg_type     rd;
      logic        sub;      // acc = sat(rc - mulq(ra,rb))
      logic        add;      // acc = sat(rc + mulq(ra,rb))
      logic        div_lam;  // divide by lambda instead of den
      reg_type     dst;
      logic        wr_pred;  // also latch prediction
   } cmd_type;

   typedef struct packed {
      logic busy;
   } sts_type;

   function automatic word_type sat_w(input logic signed [DataWidth+1:0] v);
      if (v > $signed({{2{SMax[DataWidth-1]}}, SMax})) return SMax;
      if (v < $signed({{2{SMin[DataWidth-1]}}, SMin})) return SMin;
      return v[DataWidth-1:0];
   endfunction

endpackage

[rtl/core/rls_stream_if.sv]
// ----------------------------------------------------------------------------
// rls_stream_if
// Valid/ready channel carrying a request or result payload.
// ----------------------------------------------------------------------------
interface rls_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/rls_mul.sv]
// ----------------------------------------------------------------------------
// rls_mul
// Registered fixed-point multiply: round half away from zero, saturate.
// ----------------------------------------------------------------------------
module rls_mul
   import rls_pkg::*;
(
   input  logic     clock,
   input  word_type a,
   input  word_type b,
   output word_type q_ff
);
   logic [DataWidth-1:0]   ma, mb;
   logic [ProdWidth-1:0]   p;
   logic [ProdWidth:0]     pr;
   logic [ProdWidth-FracBits:0] sh;
   logic                   neg;
   word_type               q_in;

   // magnitude product, rounded and clamped
   always_comb begin
      ma  = a[DataWidth-1] ? DataWidth'(-a) : a;
      mb  = b[DataWidth-1] ? DataWidth'(-b) : b;
      neg = a[DataWidth-1] ^ b[DataWidth-1];
      p   = ma * mb;
      pr  = {1'b0, p} + (ProdWidth+1)'(1 << (FracBits-1));
      sh  = pr[ProdWidth:FracBits];
      if (neg) begin
         if (sh > (ProdWidth-FracBits+1)'({1'b1, {(DataWidth-1){1'b0}}})) q_in = SMin;
         else q_in = DataWidth'(-sh);
      end else begin
         if (sh > (ProdWidth-FracBits+1)'(SMax)) q_in = SMax;
         else q_in = sh[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end
endmodule

[rtl/core/rls_div.sv]
// ----------------------------------------------------------------------------
// rls_div
// Restoring divider, one quotient bit per cycle: (n << FracBits) / d.
// ----------------------------------------------------------------------------
module rls_div
   import rls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type num,
   input  word_type den,
   output logic     done_ff,
   output word_type q_out
);
   localparam int NW = DataWidth + FracBits;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]        n_ff, n_in;
   logic [NW-1:0]        qt_ff, qt_in;
   logic [DataWidth:0]   r_ff, r_in;
   logic [DataWidth-1:0] d_ff, d_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 run_ff, run_in, done_in;
   logic [DataWidth:0]   rs;

   always_comb begin
      n_in = n_ff; qt_in = qt_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      rs = {r_ff[DataWidth-1:0], n_ff[NW-1]};
      if (start) begin
         n_in   = {(num[DataWidth-1] ? DataWidth'(-num) : num), {FracBits{1'b0}}};
         d_in   = den[DataWidth-1] ? DataWidth'(-den) : den;
         neg_in = num[DataWidth-1] ^ den[DataWidth-1];
         r_in   = '0;
         qt_in  = '0;
         cnt_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         // one shift-subtract step
         n_in = n_ff << 1;
         if (rs >= {1'b0, d_ff}) begin
            r_in  = rs - {1'b0, d_ff};
            qt_in = {qt_ff[NW-2:0], 1'b1};
         end else begin
            r_in  = rs;
            qt_in = {qt_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // saturate signed quotient
   always_comb begin
      if (neg_ff) begin
         if (qt_ff > NW'({1'b1, {(DataWidth-1){1'b0}}})) q_out = SMin;
         else q_out = DataWidth'(-qt_ff);
      end else begin
         if (qt_ff > NW'(SMax)) q_out = SMax;
         else q_out = qt_ff[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      qt_ff  <= qt_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end
endmodule

[rtl/core/rls_datapath.sv]
// ----------------------------------------------------------------------------
// rls_datapath
// Register file, two shared multipliers and a divider for the RLS update.
// ----------------------------------------------------------------------------
module rls_datapath
   import rls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                cmd_go,
   output logic                div_done,
   // load controls from the top-level request and register logic
   input  logic                ld_req,
   input  word_type            phi0,
   input  word_type            phi1,
   input  word_type            y,
   input  logic                do_restart,
   input  logic                do_load,
   input  word_type            new_th0,
   input  word_type            new_th1,
   input  logic                cnt_inc,
   input  logic                cfg_th0_we,
   input  logic                cfg_th1_we,
   input  word_type            cfg_th_val,
   input  logic [LamWidth-1:0] lambda,
   input  logic [DelWidth-1:0] delta,
   output word_type            th0,
   output word_type            th1,
   output word_type            pred,
   output logic [DataWidth-1:0] count
);
   word_type rf_ff [16];
   word_type rf_in [16];
   word_type pred_ff, pred_in;
   logic [DataWidth-1:0] cnt_ff, cnt_in;
   word_type m0, m1;
   word_type dq;
   word_type acc;
   word_type dsub;
   logic signed [DataWidth+1:0] lsum;

   rls_mul u_mul0 (.clock(clock), .a(rf_ff[cmd.ra]), .b(rf_ff[cmd.rb]), .q_ff(m0));
   rls_mul u_mul1 (.clock(clock), .a(rf_ff[cmd.rc]), .b(rf_ff[cmd.rd]), .q_ff(m1));

   rls_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd_go && cmd.dop == DO_DIV),
      .num    (rf_ff[cmd.ra]),
      .den    (cmd.div_lam ? word_type'({{(DataWidth-LamWidth){1'b0}}, lambda})
                           : rf_ff[R_DEN]),
      .done_ff(div_done),
      .q_out  (dq)
   );

   // combine multiplier outputs (registered products)
   always_comb begin
      if (cmd.sub)
         acc = sat_w({{2{rf_ff[cmd.rc][DataWidth-1]}}, rf_ff[cmd.rc]} - {{2{m0[DataWidth-1]}}, m0});
      else if (cmd.add)
         acc = sat_w({{2{rf_ff[cmd.rc][DataWidth-1]}}, rf_ff[cmd.rc]} + {{2{m0[DataWidth-1]}}, m0});
      else
         acc = sat_w({{2{m0[DataWidth-1]}}, m0} + {{2{m1[DataWidth-1]}}, m1});
      dsub = sat_w({{2{rf_ff[cmd.rc][DataWidth-1]}}, rf_ff[cmd.rc]}
                 - {{2{rf_ff[cmd.ra][DataWidth-1]}}, rf_ff[cmd.ra]});
      lsum = {{(DataWidth+2-LamWidth){1'b0}}, lambda}
           + {{2{rf_ff[R_DEN][DataWidth-1]}}, rf_ff[R_DEN]};
   end

   // register file writes
   always_comb begin
      rf_in   = rf_ff;
      pred_in = pred_ff;
      cnt_in  = cnt_ff;
      if (ld_req) begin
         rf_in[R_PHI0] = phi0;
         rf_in[R_PHI1] = phi1;
         rf_in[R_Y]    = y;
      end
      if (cmd_go) begin
         case (cmd.dop)
            DO_MULACC: begin
               rf_in[cmd.dst] = acc;
               if (cmd.wr_pred) pred_in = acc;
            end
            DO_ADDLAM: begin
               rf_in[R_DEN] = (sat_w(lsum) == '0) ? word_type'(1) : sat_w(lsum);
            end
            DO_SUB: begin
               rf_in[cmd.dst] = dsub;
            end
            default: ;
         endcase
      end
      if (div_done) rf_in[cmd.dst] = dq;
      if (cnt_inc) cnt_in = cnt_ff + 1'b1;
      if (do_load) begin
         rf_in[R_TH0] = new_th0;
         rf_in[R_TH1] = new_th1;
      end
      if (cfg_th0_we) rf_in[R_TH0] = cfg_th_val;
      if (cfg_th1_we) rf_in[R_TH1] = cfg_th_val;
      if (do_restart) begin
         rf_in[R_P00] = word_type'({1'b0, delta});
         rf_in[R_P01] = '0;
         rf_in[R_P10] = '0;
         rf_in[R_P11] = word_type'({1'b0, delta});
         rf_in[R_TH0] = '0;
         rf_in[R_TH1] = '0;
         pred_in      = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) rf_ff[i] <= '0;
         rf_ff[R_P00] <= word_type'(LamOne);
         rf_ff[R_P11] <= word_type'(LamOne);
         pred_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         rf_ff   <= rf_in;
         pred_ff <= pred_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign th0   = rf_ff[R_TH0];
   assign th1   = rf_ff[R_TH1];
   assign pred  = pred_ff;
   assign count = cnt_ff;
endmodule

[rtl/core/rls_ctrl.sv]
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer that steps the datapath through one RLS update microprogram.
// ----------------------------------------------------------------------------
module rls_ctrl
   import rls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start_upd,
   input  logic    div_done,
   output cmd_type cmd,
   output logic    cmd_go,
   output logic    cnt_inc,
   output sts_type sts
);
   typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_type;

   state_type  st_ff, st_in;
   logic [4:0] pc_ff, pc_in;
   logic       go_in, inc_in;
   cmd_type    c;
   logic       last;

   localparam logic [4:0] LastStep = 5'd20;

   // microprogram
   always_comb begin
      c = '0;
      unique case (pc_ff)
         5'd0:  begin c.dop = DO_MULACC; c.ra = R_P00; c.rb = R_PHI0; c.rc = R_P01; c.rd = R_PHI1; c.dst = R_T0; end
         5'd1:  begin c.dop = DO_MULACC; c.ra = R_P10; c.rb = R_PHI0; c.rc = R_P11; c.rd = R_PHI1; c.dst = R_T1; end
         5'd2:  begin c.dop = DO_MULACC; c.ra = R_PHI0; c.rb = R_T0; c.rc = R_PHI1; c.rd = R_T1; c.dst = R_DEN; end
         5'd3:  begin c.dop = DO_ADDLAM; end
         5'd4:  begin c.dop = DO_DIV; c.ra = R_T0; c.dst = R_K0; end
         5'd5:  begin c.dop = DO_DIV; c.ra = R_T1; c.dst = R_K1; end
         5'd6:  begin c.dop = DO_MULACC; c.ra = R_PHI0; c.rb = R_TH0; c.rc = R_PHI1; c.rd = R_TH1; c.dst = R_T0; c.wr_pred = 1'b1; end
         5'd7:  begin c.dop = DO_SUB; c.ra = R_T0; c.rc = R_Y; c.dst = R_ERR; end
         5'd8:  begin c.dop = DO_MULACC; c.ra = R_K0; c.rb = R_ERR; c.rc = R_TH0; c.add = 1'b1; c.dst = R_TH0; end
         5'd9:  begin c.dop = DO_MULACC; c.ra = R_K1; c.rb = R_ERR; c.rc = R_TH1; c.add = 1'b1; c.dst = R_TH1; end
         5'd10: begin c.dop = DO_MULACC; c.ra = R_PHI0; c.rb = R_P00; c.rc = R_PHI1; c.rd = R_P10; c.dst = R_S0; end
         5'd11: begin c.dop = DO_MULACC; c.ra = R_PHI0; c.rb = R_P01; c.rc = R_PHI1; c.rd = R_P11; c.dst = R_T1; end
         5'd12: begin c.dop = DO_MULACC; c.ra = R_K0; c.rb = R_S0; c.rc = R_P00; c.sub = 1'b1; c.dst = R_P00; end
         5'd13: begin c.dop = DO_MULACC; c.ra = R_K0; c.rb = R_T1; c.rc = R_P01; c.sub = 1'b1; c.dst = R_P01; end
         5'd14: begin c.dop = DO_MULACC; c.ra = R_K1; c.rb = R_S0; c.rc = R_P10; c.sub = 1'b1; c.dst = R_P10; end
         5'd15: begin c.dop = DO_MULACC; c.ra = R_K1; c.rb = R_T1; c.rc = R_P11; c.sub = 1'b1; c.dst = R_P11; end
         // covariance scaled by one over lambda
         5'd16: begin c.dop = DO_DIV; c.ra = R_P00; c.div_lam = 1'b1; c.dst = R_P00; end
         5'd17: begin c.dop = DO_DIV; c.ra = R_P01; c.div_lam = 1'b1; c.dst = R_P01; end
         5'd18: begin c.dop = DO_DIV; c.ra = R_P10; c.div_lam = 1'b1; c.dst = R_P10; end
         5'd19: begin c.dop = DO_DIV; c.ra = R_P11; c.div_lam = 1'b1; c.dst = R_P11; end
         default: begin c.dop = DO_IDLE; end
      endcase
   end

   // step 7 forms err = y - pred with pred held in T0
   always_comb begin
      cmd  = c;
      last = (pc_ff == LastStep);
   end

   always_comb begin
      st_in = st_ff; pc_in = pc_ff; go_in = 1'b0; inc_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (start_upd) begin
            st_in = S_ISSUE; pc_in = '0;
         end
         S_ISSUE: begin
            // products register at this edge, write or divider start follows
            st_in = S_WAIT;
            go_in = 1'b1;
         end
         S_WAIT: begin
            if (c.dop == DO_DIV) begin
               if (div_done) begin
                  pc_in = pc_ff + 1'b1; st_in = S_ISSUE;
               end
            end else begin
               pc_in = pc_ff + 1'b1; st_in = S_ISSUE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff != S_IDLE && last) begin
         st_in = S_IDLE; go_in = 1'b0; inc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pc_ff <= '0; cmd_go <= 1'b0; cnt_inc <= 1'b0;
      end else begin
         st_ff <= st_in; pc_ff <= pc_in; cmd_go <= go_in; cnt_inc <= inc_in;
      end
   end

   assign sts.busy = (st_ff != S_IDLE) || cnt_inc;
endmodule

[rtl/core/rls_two_param_estimator_top.sv]
// ----------------------------------------------------------------------------
// rls_two_param_estimator_top
// Two-parameter RLS estimator with forgetting factor, Q16.16.
// ----------------------------------------------------------------------------
// An update request runs fourteen microprogram steps (twelve on the shared
// multiplier pair, one lambda add, one error subtract) and six divisions
// (two for the gain, four for the covariance), all on one bit-serial
// divider of 48 steps; then the count is bumped and the output register
// loaded. Restart, load and unused-op requests reach the output register
// through a registered flag. One request is worked on at a time; the
// next request is accepted once the previous result is taken or being taken.
module rls_two_param_estimator_top
   import rls_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_op,
   input  word_type req_regressor_first,
   input  word_type req_regressor_second,
   input  word_type req_measured_output,
   input  word_type req_new_theta_first,
   input  word_type req_new_theta_second,
   output logic rsp_valid,
   input  logic rsp_ready,
   output word_type rsp_theta_first,
   output word_type rsp_theta_second,
   output word_type rsp_prediction,
   output logic [DataWidth-1:0] rsp_update_count,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [LamWidth-1:0] lam_ff;
   logic [DelWidth-1:0] del_ff;
   word_type it0_ff, it1_ff;
   logic wr;
   cmd_type cmd;
   logic cmd_go, cnt_inc, div_done, start_upd, ld_req;
   sts_type sts;
   word_type th0, th1, pred;
   logic [DataWidth-1:0] cnt;
   logic pend_ff, pend_in, post_ff, tail_ff, tail_in;
   logic ov_ff;
   word_type o0_ff, o1_ff, o2_ff;
   logic [DataWidth-1:0] o3_ff;
   logic fin;

   // configuration registers
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff <= LamOne; del_ff <= DelWidth'(LamOne); it0_ff <= '0; it1_ff <= '0;
      end else if (wr) begin
         unique case (csr_paddr)
            REG_LAMBDA: if (csr_pwdata[LamWidth-1:0] != '0 && csr_pwdata[LamWidth-1:0] <= LamOne)
               lam_ff <= csr_pwdata[LamWidth-1:0];
            REG_DELTA: if (csr_pwdata[DelWidth-1:0] != '0) del_ff <= csr_pwdata[DelWidth-1:0];
            REG_THETA0: it0_ff <= csr_pwdata;
            REG_THETA1: it1_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr)
         REG_LAMBDA: csr_prdata = 32'(lam_ff);
         REG_DELTA:  csr_prdata = 32'(del_ff);
         REG_THETA0: csr_prdata = it0_ff;
         REG_THETA1: csr_prdata = it1_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // request intake: one request in flight, output register holds results
   assign req_ready = !pend_ff && !sts.busy && !tail_ff && !post_ff &&
                      !(rsp_valid && !rsp_ready);
   assign ld_req    = req_valid && req_ready;
   assign start_upd = ld_req && req_op == OP_UPDATE;
   assign tail_in   = ld_req && req_op != OP_UPDATE;
   assign fin       = (post_ff) || tail_ff;

   rls_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start_upd(start_upd), .div_done(div_done),
      .cmd(cmd), .cmd_go(cmd_go), .cnt_inc(cnt_inc), .sts(sts)
   );

   rls_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_go(cmd_go), .div_done(div_done),
      .ld_req(ld_req), .phi0(req_regressor_first), .phi1(req_regressor_second),
      .y(req_measured_output), .do_restart(ld_req && req_op == OP_RESTART),
      .do_load(ld_req && req_op == OP_LOAD), .new_th0(req_new_theta_first),
      .new_th1(req_new_theta_second), .cnt_inc(cnt_inc),
      .cfg_th0_we(wr && csr_paddr == REG_THETA0),
      .cfg_th1_we(wr && csr_paddr == REG_THETA1), .cfg_th_val(csr_pwdata),
      .lambda(lam_ff), .delta(del_ff),
      .th0(th0), .th1(th1), .pred(pred), .count(cnt)
   );

   // track update completion
   assign pend_in = start_upd ? 1'b1 : (cnt_inc ? 1'b0 : pend_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0; post_ff <= 1'b0; tail_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         post_ff <= cnt_inc;
         tail_ff <= tail_in;
         if (fin) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
      if (fin) begin
         o0_ff <= th0; o1_ff <= th1; o2_ff <= pred; o3_ff <= cnt;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_theta_first  = o0_ff;
   assign rsp_theta_second = o1_ff;
   assign rsp_prediction   = o2_ff;
   assign rsp_update_count = o3_ff;

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      ld_req |=> !req_ready) else $error("second request taken while busy");
   a_fin_no_stall: assert property (@(posedge clock) disable iff (reset)
      fin |-> !(rsp_valid && !rsp_ready)) else $error("result overwritten");
   a_update_ends: assert property (@(posedge clock) disable iff (reset)
      cnt_inc |-> pend_ff) else $error("count bump without update");
endmodule

[tb/tb_rls_two_param_estimator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rls_two_param_estimator_top
// Self-checking bench for the two-parameter RLS estimator. Requests come from
// a queue through a clocked driver. A bit-exact fixed-point estimator model
// predicts each result, and a clocked monitor compares each result whole,
// all fields at once. Runs go through several lambda/delta/theta settings
// with random gaps and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_rls_two_param_estimator_top;
   import rls_pkg::*;

   typedef struct packed {
      op_type   op;
      word_type phi0;
      word_type phi1;
      word_type y;
      word_type th0_new;
      word_type th1_new;
   } request_type;

   typedef struct packed {
      word_type          th0;
      word_type          th1;
      word_type          pred;
      logic [31:0]       count;
   } estimate_type;

   localparam longint WMax = 64'sd2147483647;
   localparam longint WMin = -64'sd2147483648;
   localparam int StallLen = 700;
   localparam int WatchLimit = 30000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   rls_stream_if #(.payload_type(request_type)) req_ch ();
   rls_stream_if #(.payload_type(estimate_type)) rsp_ch ();

   rls_two_param_estimator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_op(req_ch.payload.op),
      .req_regressor_first(req_ch.payload.phi0),
      .req_regressor_second(req_ch.payload.phi1),
      .req_measured_output(req_ch.payload.y),
      .req_new_theta_first(req_ch.payload.th0_new),
      .req_new_theta_second(req_ch.payload.th1_new),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_theta_first(rsp_ch.payload.th0),
      .rsp_theta_second(rsp_ch.payload.th1),
      .rsp_prediction(rsp_ch.payload.pred),
      .rsp_update_count(rsp_ch.payload.count),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // estimator model state
   longint      lam_q, delta_q;
   longint      cov[4];
   longint      theta_q[2];
   longint      last_pred;
   logic [31:0] upd_count;

   request_type  pending_requests[$];
   estimate_type expected_estimates[$];
   int mismatches = 0;
   int results_seen = 0;
   int n_update = 0, n_restart = 0, n_load = 0, n_none = 0, n_csr = 0;
   int cycle_cnt = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit stall_done = 0;
   bit no_idle = 0;

   function automatic longint clip(longint v);
      return v > WMax ? WMax : (v < WMin ? WMin : v);
   endfunction

   function automatic logic [63:0] magn(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint pack_mag(logic neg, logic [127:0] m);
      if (neg) begin
         if (m > 128'd2147483648) return WMin;
         return -longint'(m[62:0]);
      end
      if (m > 128'd2147483647) return WMax;
      return longint'(m[62:0]);
   endfunction

   // product rounded to nearest, ties away from zero
   function automatic longint fx_mul(longint a, longint b);
      logic [127:0] m;
      m = 128'(magn(a)) * 128'(magn(b));
      m = (m + 128'(32768)) >> FracBits;
      return pack_mag((a < 0) != (b < 0), m);
   endfunction

   // quotient truncated toward zero
   function automatic longint fx_div(longint num, longint den);
      logic [127:0] m;
      m = (128'(magn(num)) << FracBits) / 128'(magn(den));
      return pack_mag((num < 0) != (den < 0), m);
   endfunction

   function automatic void restart_estimator();
      cov[0] = delta_q;
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = delta_q;
      theta_q[0] = 0;
      theta_q[1] = 0;
      last_pred = 0;
      upd_count = 0;
   endfunction

   function automatic void model_update(longint phi0, longint phi1, longint y);
      longint p00, p01, p10, p11, t0, t1, den, k0, k1, pred, err, s0, s1;
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      t0 = clip(fx_mul(p00, phi0) + fx_mul(p01, phi1));
      t1 = clip(fx_mul(p10, phi0) + fx_mul(p11, phi1));
      den = clip(lam_q + clip(fx_mul(phi0, t0) + fx_mul(phi1, t1)));
      // zero denominator forced to one lsb
      if (den == 0) den = 1;
      k0 = fx_div(t0, den);
      k1 = fx_div(t1, den);
      pred = clip(fx_mul(phi0, theta_q[0]) + fx_mul(phi1, theta_q[1]));
      err = clip(y - pred);
      theta_q[0] = clip(theta_q[0] + fx_mul(k0, err));
      theta_q[1] = clip(theta_q[1] + fx_mul(k1, err));
      s0 = clip(fx_mul(phi0, p00) + fx_mul(phi1, p10));
      s1 = clip(fx_mul(phi0, p01) + fx_mul(phi1, p11));
      cov[0] = fx_div(clip(p00 - fx_mul(k0, s0)), lam_q);
      cov[1] = fx_div(clip(p01 - fx_mul(k0, s1)), lam_q);
      cov[2] = fx_div(clip(p10 - fx_mul(k1, s0)), lam_q);
      cov[3] = fx_div(clip(p11 - fx_mul(k1, s1)), lam_q);
      upd_count = upd_count + 1;
      last_pred = pred;
   endfunction

   function automatic estimate_type estimate_after(request_type r);
      estimate_type e;
      case (r.op)
         OP_UPDATE: begin
            model_update(longint'(r.phi0), longint'(r.phi1), longint'(r.y));
            n_update++;
         end
         OP_RESTART: begin
            restart_estimator();
            n_restart++;
         end
         OP_LOAD: begin
            theta_q[0] = longint'(r.th0_new);
            theta_q[1] = longint'(r.th1_new);
            n_load++;
         end
         default: n_none++;
      endcase
      e.th0 = word_type'(theta_q[0]);
      e.th1 = word_type'(theta_q[1]);
      e.pred = word_type'(last_pred);
      e.count = upd_count;
      return e;
   endfunction

   function automatic void apply_csr(logic [AddrWidth-1:0] addr, logic [31:0] v);
      logic [31:0] masked;
      case (addr)
         REG_LAMBDA: begin
            masked = v & 32'h1ffff;
            if (masked != 0 && masked <= 32'h10000) lam_q = longint'(masked);
         end
         REG_DELTA: begin
            masked = v & 32'h7fffffff;
            if (masked != 0) delta_q = longint'(masked);
         end
         REG_THETA0: theta_q[0] = longint'(signed'(v));
         REG_THETA1: theta_q[1] = longint'(signed'(v));
         default: ;
      endcase
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_estimates.push_back(estimate_after(pending_requests.pop_front()));
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_requests.size() > 0 && (no_idle || $urandom_range(99) >= 11)) begin
               req_ch.valid <= 1;
               req_ch.payload <= pending_requests[0];
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_estimates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_ch.payload);
            end else if (rsp_ch.payload !== expected_estimates[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p",
                           expected_estimates[0], rsp_ch.payload);
               void'(expected_estimates.pop_front());
            end else begin
               void'(expected_estimates.pop_front());
            end
         end
         // one long hold-off so the block fills and stalls its input
         if (!stall_done && results_seen == 150) begin
            stall_done <= 1;
            stall_left <= StallLen;
            rsp_ch.ready <= 0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= no_idle || $urandom_range(99) >= 11;
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_estimates.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [AddrWidth-1:0] addr, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      apply_csr(addr, v);
      n_csr++;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic request_type make_request(op_type op, longint a, longint b,
                                                longint c, longint d, longint e);
      request_type r;
      r.op = op;
      r.phi0 = word_type'(a);
      r.phi1 = word_type'(b);
      r.y = word_type'(c);
      r.th0_new = word_type'(d);
      r.th1_new = word_type'(e);
      return r;
   endfunction

   // well-formed update around a hidden parameter pair; otherwise a restart, load, unused op or full-range noise update
   function automatic request_type random_request(longint true0, longint true1);
      request_type r;
      longint p0, p1, yv;
      int pick;
      pick = $urandom_range(99);
      r = make_request(OP_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (pick < 70) begin
         p0 = longint'($urandom_range(262144)) - 131072;
         p1 = longint'($urandom_range(262144)) - 131072;
         yv = fx_mul(p0, true0) + fx_mul(p1, true1) + longint'($urandom_range(512)) - 256;
         r.phi0 = word_type'(p0);
         r.phi1 = word_type'(p1);
         r.y = word_type'(clip(yv));
      end else if (pick < 80) begin
         r.op = OP_RESTART;
      end else if (pick < 88) begin
         r.op = OP_LOAD;
      end else if (pick < 91) begin
         r.op = OP_NONE;
      end
      return r;
   endfunction

   initial begin
      longint lam_set[4];
      logic [31:0] delta_set[4];
      longint true0, true1;
      lam_set = '{65536, 1, 65000, 60000};
      delta_set = '{32'h10000, 32'h7fffffff, 32'h1, 32'h200000};
      reset = 1;
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      lam_q = 65536;
      delta_q = 65536;
      restart_estimator();
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: extremes, every op, zero regressor, count after restart
      pending_requests.push_back(make_request(OP_NONE, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_UPDATE, 65536, 0, 131072, 0, 0));
      pending_requests.push_back(make_request(OP_UPDATE, 0, 0, 12345, 0, 0));
      pending_requests.push_back(make_request(OP_UPDATE, WMax, WMax, WMax, 0, 0));
      pending_requests.push_back(make_request(OP_UPDATE, WMin, WMin, WMin, 0, 0));
      pending_requests.push_back(make_request(OP_UPDATE, WMin, WMax, 0, 0, 0));
      pending_requests.push_back(make_request(OP_LOAD, -1, -1, -1, WMax, WMin));
      pending_requests.push_back(make_request(OP_UPDATE, 1, -1, 1, 0, 0));
      pending_requests.push_back(make_request(OP_LOAD, 0, 0, 0, WMin, WMax));
      pending_requests.push_back(make_request(OP_NONE, WMax, WMin, WMax, 1, -1));
      pending_requests.push_back(make_request(OP_RESTART, WMax, WMax, WMax, WMax, WMax));
      pending_requests.push_back(make_request(OP_UPDATE, -65536, 65536, -65536, 0, 0));
      pending_requests.push_back(make_request(OP_LOAD, 0, 0, 0, 0, 0));
      wait_drained();

      // out-of-range writes that must be ignored, then a lambda write of one with high bits set
      csr_write(REG_LAMBDA, 32'h0);
      csr_write(REG_LAMBDA, 32'h10001);
      csr_write(REG_DELTA, 32'h80000000);
      csr_write(REG_LAMBDA, 32'h80010000);

      for (int ph = 0; ph < 4; ph++) begin
         no_idle = (ph == 2);
         csr_write(REG_LAMBDA, 32'(lam_set[ph]));
         csr_write(REG_DELTA, delta_set[ph]);
         csr_write(REG_THETA0, ph == 1 ? 32'h7fffffff : $urandom);
         csr_write(REG_THETA1, ph == 1 ? 32'h80000000 : $urandom);
         true0 = longint'($urandom_range(262144)) - 131072;
         true1 = longint'($urandom_range(262144)) - 131072;
         // updates first use the start values, then a restart
         for (int i = 0; i < 225; i++) begin
            if (i == 3) pending_requests.push_back(make_request(OP_RESTART, 0, 0, 0, 0, 0));
            else pending_requests.push_back(random_request(true0, true1));
         end
         wait_drained();
      end

      $display("covered %0d updates, %0d restarts, %0d loads, %0d unused ops",
               n_update, n_restart, n_load, n_none);
      $display("%0d register writes, %0d results checked, %0d mismatches, %0d cycles",
               n_csr, results_seen, mismatches, cycle_cnt);
      if (mismatches == 0 && expected_estimates.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
